// ===== design/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants, types and the exp2 table of the logit token sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

	localparam int VOCAB_MAX = 32768;
	localparam int ADDR_W    = $clog2(VOCAB_MAX);
	localparam int CNT_W     = $clog2(VOCAB_MAX + 1);
	localparam int TOK_W     = 15;
	localparam int LOGIT_W   = 16;
	localparam int TOTAL_W   = 48;
	localparam int WEIGHT_W  = 25;

	// log2(e) in Q1.30
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	// configuration register indexes
	localparam logic REG_SAMPLE_MODE = 1'b0;
	localparam logic REG_INV_TEMP    = 1'b1;

	// sampling modes
	localparam logic MODE_GREEDY = 1'b0;
	localparam logic MODE_TEMP   = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SUM,
		ST_THR_LO,
		ST_THR_HI,
		ST_PICK,
		ST_EMIT
	} lts_state_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic issue;
		logic pick;
		logic thr_lo;
		logic thr_hi;
		logic emit_greedy;
		logic emit_scan;
	} lts_cmd_t;

	typedef struct packed {
		logic issue_done;
		logic pipe_empty;
		logic mode;
	} lts_sts_t;

	// round(2^24 * 2^(-k/16)) for k = 0..16
	function automatic logic [WEIGHT_W-1:0] exp2_val(input logic [4:0] k);
		logic [WEIGHT_W-1:0] v;
		case (k)
			5'd0:    v = 25'd16777216;
			5'd1:    v = 25'd16065917;
			5'd2:    v = 25'd15384775;
			5'd3:    v = 25'd14732511;
			5'd4:    v = 25'd14107901;
			5'd5:    v = 25'd13509772;
			5'd6:    v = 25'd12937002;
			5'd7:    v = 25'd12388516;
			5'd8:    v = 25'd11863283;
			5'd9:    v = 25'd11360319;
			5'd10:   v = 25'd10878679;
			5'd11:   v = 25'd10417458;
			5'd12:   v = 25'd9975792;
			5'd13:   v = 25'd9552851;
			5'd14:   v = 25'd9147842;
			5'd15:   v = 25'd8760003;
			5'd16:   v = 25'd8388608;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== design/lts_ram.sv =====
// ----------------------------------------------------------------------------
// lts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/lts_dp.sv =====
// ----------------------------------------------------------------------------
// lts_dp
// Datapath: logit store, running maximum, weight pipeline, totals and
// threshold, choice and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_dp
	import lts_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lts_cmd_t                  cmd,
	output lts_sts_t                       sts,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [15:0]               cfg_data,
	input  wire logic signed [LOGIT_W-1:0] logit,
	input  wire logic [15:0]               random_fraction,
	output logic      [TOK_W-1:0]          token_index,
	output logic                           overflowed
);

	logic                      mode_q;
	logic [15:0]               invt_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [LOGIT_W-1:0] best_q;
	logic [ADDR_W-1:0]         best_idx_q;
	logic                      ovf_q;
	logic [15:0]               rnd_q;
	logic [CNT_W-1:0]          addr_q;
	logic [TOTAL_W-1:0]        total_q;
	logic [39:0]               part_q;
	logic [TOTAL_W-1:0]        thr_q;
	logic [TOTAL_W-1:0]        run_q;
	logic                      found_q;
	logic [ADDR_W-1:0]         choice_q;

	logic                      full;
	logic                      better;
	logic [ADDR_W-1:0]         best_idx_nx;
	logic                      ovf_nx;
	logic                      ren;
	logic [LOGIT_W-1:0]        rdata;

	logic                      vld_s0, vld_s1, vld_s2, vld_s3, vld_s4;
	logic [ADDR_W-1:0]         idx_s0, idx_s1, idx_s2, idx_s3, idx_s4;
	logic [31:0]               p_s1;
	logic [32:0]               y_s2;
	logic [31:0]               prod_s3;
	logic [WEIGHT_W-1:0]       t0_s3;
	logic [4:0]                sh_s3;
	logic                      zero_s3;
	logic [WEIGHT_W-1:0]       w_s4;

	logic [16:0]               diff17;
	logic [62:0]               prod63;
	logic [16:0]               n_val;
	logic [3:0]                seg;
	logic [11:0]               frac;
	logic [WEIGHT_W-1:0]       t0, t1;
	logic [19:0]               tdiff;
	logic [32:0]               corr;
	logic [WEIGHT_W-1:0]       v_val;
	logic [TOTAL_W-1:0]        run_nx;
	logic [39:0]               hi_part;
	logic [63:0]               thr_sum;
	logic [CNT_W-1:0]          last_idx;

	// store and running maximum for the incoming logit
	assign full        = !(count_q < CNT_W'(VOCAB_MAX));
	assign better      = !full && (logit > best_q);
	assign best_idx_nx = better ? count_q[ADDR_W-1:0] : best_idx_q;
	assign ovf_nx      = ovf_q || full;
	assign ren         = cmd.issue && (addr_q < count_q);
	assign last_idx    = count_q - 1'b1;

	lts_ram #(
		.WIDTH(LOGIT_W),
		.DEPTH(VOCAB_MAX)
	) u_store (
		.clk   (clk),
		.we    (cmd.load && !full),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (logit),
		.re    (ren),
		.raddr (addr_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	// weight arithmetic, one step per stage
	always_comb begin
		diff17  = {best_q[LOGIT_W-1], best_q} - {rdata[LOGIT_W-1], rdata};
		prod63  = 63'(p_s1) * 63'(LOG2E_Q30);
		n_val   = y_s2[32:16];
		seg     = y_s2[15:12];
		frac    = y_s2[11:0];
		t0      = exp2_val({1'b0, seg});
		t1      = exp2_val(5'({1'b0, seg}) + 5'd1);
		tdiff   = 20'(t0 - t1);
		corr    = 33'(prod_s3) + 33'd2048;
		v_val   = t0_s3 - WEIGHT_W'(corr[32:12]);
		run_nx  = run_q + TOTAL_W'(w_s4);
		hi_part = 40'(total_q[47:24]) * 40'(rnd_q);
		thr_sum = {hi_part, 24'd0} + 64'(part_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GREEDY;
			invt_q <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_MODE: mode_q <= cfg_data[0];
				REG_INV_TEMP:    invt_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// vocabulary state: load, close and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			best_q     <= 16'sh8000;
			best_idx_q <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.emit_greedy || cmd.emit_scan) begin
			count_q    <= '0;
			best_q     <= 16'sh8000;
			best_idx_q <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.load) begin
			if (!full) begin
				count_q <= count_q + 1'b1;
			end
			if (better) begin
				best_q <= logit;
			end
			best_idx_q <= best_idx_nx;
			ovf_q      <= ovf_nx;
		end
	end

	// scan address and pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (cmd.scan_start || cmd.thr_hi) begin
				addr_q <= '0;
			end else if (ren) begin
				addr_q <= addr_q + 1'b1;
			end
			vld_s0 <= ren;
			vld_s1 <= vld_s0;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// weight pipeline payload
	always_ff @(posedge clk) begin
		idx_s0  <= addr_q[ADDR_W-1:0];
		idx_s1  <= idx_s0;
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		idx_s4  <= idx_s3;
		p_s1    <= 32'(diff17[15:0]) * 32'(invt_q);
		y_s2    <= prod63[62:30];
		prod_s3 <= 32'(tdiff) * 32'(frac);
		t0_s3   <= t0;
		sh_s3   <= n_val[4:0];
		zero_s3 <= n_val > 17'd24;
		w_s4    <= zero_s3 ? '0 : (v_val >> sh_s3);
	end

	// totals, threshold and choice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			found_q  <= 1'b0;
			run_q    <= '0;
		end else begin
			if (cmd.scan_start) begin
				total_q <= '0;
			end else if (vld_s4 && !cmd.pick) begin
				total_q <= total_q + TOTAL_W'(w_s4);
			end
			if (cmd.thr_hi) begin
				run_q   <= '0;
				found_q <= 1'b0;
			end else if (vld_s4 && cmd.pick) begin
				run_q <= run_nx;
				if (!found_q && (run_nx > thr_q)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			rnd_q <= random_fraction;
		end
		if (cmd.thr_lo) begin
			part_q <= 40'(total_q[23:0]) * 40'(rnd_q);
		end
		if (cmd.thr_hi) begin
			thr_q <= thr_sum[63:16];
		end
		if (vld_s4 && cmd.pick && !found_q && (run_nx > thr_q)) begin
			choice_q <= idx_s4;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.emit_greedy) begin
			token_index <= TOK_W'(best_idx_nx);
			overflowed  <= ovf_nx;
		end else if (cmd.emit_scan) begin
			if (count_q == '0) begin
				token_index <= '0;
			end else if (found_q) begin
				token_index <= TOK_W'(choice_q);
			end else begin
				token_index <= TOK_W'(last_idx);
			end
			overflowed <= ovf_q;
		end
	end

	assign sts.issue_done = !(addr_q < count_q);
	assign sts.pipe_empty = !(vld_s0 || vld_s1 || vld_s2 || vld_s3 || vld_s4);
	assign sts.mode       = mode_q;

endmodule

`default_nettype wire

// ===== design/lts_ctrl.sv =====
// ----------------------------------------------------------------------------
// lts_ctrl
// Controller: input and output handshakes and the sequence of the two scans.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_ctrl
	import lts_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     is_last,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire lts_sts_t sts,
	output lts_cmd_t      cmd
);

	lts_state_t state_q, state_nx;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_LOAD) && (!is_last || out_free);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			ST_LOAD: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (is_last) begin
						if (sts.mode == MODE_TEMP) begin
							cmd.scan_start = 1'b1;
							state_nx       = ST_SUM;
						end else begin
							cmd.emit_greedy = 1'b1;
						end
					end
				end
			end
			ST_SUM: begin
				cmd.issue = 1'b1;
				if (sts.issue_done && sts.pipe_empty) begin
					state_nx = ST_THR_LO;
				end
			end
			ST_THR_LO: begin
				cmd.thr_lo = 1'b1;
				state_nx   = ST_THR_HI;
			end
			ST_THR_HI: begin
				cmd.thr_hi = 1'b1;
				state_nx   = ST_PICK;
			end
			ST_PICK: begin
				cmd.issue = 1'b1;
				cmd.pick  = 1'b1;
				if (sts.issue_done && sts.pipe_empty) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit_scan = 1'b1;
					state_nx      = ST_LOAD;
				end
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	// hold the result until the receiver takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_greedy || cmd.emit_scan) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !accept)
		else $error("input transfer taken during a scan");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_scan |-> (sts.pipe_empty && sts.issue_done))
		else $error("scan result emitted before the pipeline drained");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_greedy || cmd.emit_scan) |-> out_free)
		else $error("result overwrites one not yet taken");

	a_thr_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.thr_lo |=> cmd.thr_hi)
		else $error("threshold steps out of order");

endmodule

`default_nettype wire

// ===== design/logit_token_sampler_top.sv =====
// ----------------------------------------------------------------------------
// logit_token_sampler_top
// Stores one vocabulary of logits and returns one sampled token index.
//
// Input channel (in_valid/in_ready): one signed Q8.8 logit per transfer;
// is_last closes the vocabulary and random_fraction is taken with it.
// Output channel (out_valid/out_ready): token_index and overflowed, one
// transfer per closed vocabulary. Configuration: cfg_we writes cfg_data to
// register cfg_index (0 sample_mode, 1 inv_temperature); the user must do so
// only while idle, unenforced. Logits load at one per cycle while in_ready
// is high. In greedy mode the result is registered at the closing transfer
// and appears the next cycle. In temperature mode the closing item costs two
// passes over the store through a 5-stage weight pipeline fed by the single
// RAM read port. Logits beyond 32768 are dropped and flag overflowed. Reset
// clears the vocabulary and sets greedy mode, inverse temperature 1.0. A
// stalled receiver holds the result; further logits are still taken, but the
// next closing item waits until the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module logit_token_sampler_top
	import lts_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [15:0]               cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [LOGIT_W-1:0] logit,
	input  wire logic                      is_last,
	input  wire logic [15:0]               random_fraction,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic      [TOK_W-1:0]          token_index,
	output logic                           overflowed
);

	lts_cmd_t cmd;
	lts_sts_t sts;

	lts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lts_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.logit           (logit),
		.random_fraction (random_fraction),
		.token_index     (token_index),
		.overflowed      (overflowed)
	);

endmodule

`default_nettype wire
